/* hw/rtl/icmprw_pkg.sv */
// Shared types, constants and ones-complement helpers for the ICMP rewrite block.
package icmprw_pkg;

    typedef enum logic [0:0] {
        CFG_FORCED_TYPE = 1'b0,
        CFG_FORCED_CODE = 1'b1
    } cfg_idx_t;

    localparam int unsigned MIN_IP_HDR_BYTES = 20;
    localparam int unsigned ICMP_HDR_BYTES   = 8;
    // type/code word and checksum word are the first two ICMP words
    localparam int unsigned ICMP_SUM_SKIP    = 4;

    // Two-word ones-complement add with end-around carry.
    function automatic logic [15:0] oc_add2(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        oc_add2 = s[15:0] + {15'd0, s[16]};
    endfunction

    // Three-word ones-complement sum, folded twice.
    function automatic logic [15:0] oc_add3(input logic [15:0] a, input logic [15:0] b,
                                            input logic [15:0] c);
        logic [17:0] s;
        logic [16:0] t;
        s = {2'd0, a} + {2'd0, b} + {2'd0, c};
        t = {1'b0, s[15:0]} + {15'd0, s[17:16]};
        oc_add3 = t[15:0] + {15'd0, t[16]};
    endfunction

endpackage

/* hw/rtl/icmp_type_code_rewrite_checksum.sv */
// ICMP type/code rewrite: per-byte IPv4 parse, length checks and ICMP checksum.
// Result path: the last byte's beat goes from the input register through the byte-step stage
//   into the finish register, and the finishing add then fills the output register.
// Throughput: one byte per cycle, sustained; one result beat per packet on the final byte.
// The only holdoff is output backpressure reaching a final byte through the finish stage.
// Reset (aresetn, sync, active low) clears parser, valids, config and forwarded counter.
module icmp_type_code_rewrite_checksum #(
    parameter int unsigned MAX_PACKET_BYTES = 65535
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    // configuration write port
    input  logic                  cfg_we,
    input  icmprw_pkg::cfg_idx_t  cfg_addr,
    input  logic [7:0]            cfg_wdata,

    // byte stream in
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] data_byte
    input  logic                  s_tlast,   // last_byte

    // result out
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [71:0]           m_tdata,   // [5:0] icmp_offset, [13:6] new_type,
                                             // [21:14] new_code, [37:22] new_checksum,
                                             // [69:38] forwarded_count, [71:70] zero
    output logic                  m_tuser    // drop
);
    import icmprw_pkg::*;

    // byte position width: holds 0..MAX_PACKET_BYTES (saturating)
    localparam int unsigned PW = $clog2(MAX_PACKET_BYTES + 1);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [7:0] forced_type_reg;
    logic [7:0] forced_code_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            forced_type_reg <= '0;
            forced_code_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_FORCED_TYPE: forced_type_reg <= cfg_wdata;
                CFG_FORCED_CODE: forced_code_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // handshake / pipeline advance
    //   in stage  : registered input beat
    //   fin stage : only final bytes land here (one per packet)
    //   out stage : result beat held until taken
    // ------------------------------------------------------------------
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    logic        fin_valid_reg;
    logic        fin_drop_reg;
    logic [5:0]  fin_hdr_reg;
    logic [15:0] fin_sum_reg;
    logic [7:0]  fin_pad_reg;

    logic        out_valid_reg;
    logic        out_drop_reg;
    logic [5:0]  out_offset_reg;
    logic [7:0]  out_type_reg;
    logic [7:0]  out_code_reg;
    logic [15:0] out_cksum_reg;
    logic [31:0] pkt_count_reg;

    logic out_free, fin_ready, fin_move, step, in_load;

    assign out_free  = !out_valid_reg || m_tready;
    assign fin_ready = !fin_valid_reg || out_free;
    assign fin_move  = fin_valid_reg && out_free;
    // a non-final byte only touches parser state, so it never waits
    assign step      = in_valid_reg && (!in_last_reg || fin_ready);
    assign s_tready  = !in_valid_reg || step;
    assign in_load   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_load) begin
            in_valid_reg <= 1'b1;
        end else if (step) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // ------------------------------------------------------------------
    // byte step: header parse and running ones-complement sum
    // ------------------------------------------------------------------
    logic [PW-1:0] pos_reg,  pos_next;
    logic [5:0]    hdr_reg,  hdr_next;
    logic [15:0]   tot_reg,  tot_next;
    logic [15:0]   sum_reg,  sum_next;
    logic [7:0]    held_reg, held_next;

    logic [15:0] pos16, hdr16, plen16;
    logic        pos_sat, in_icmp, bad;

    always_comb begin
        pos16   = 16'(pos_reg);
        pos_sat = (pos_reg == PW'(MAX_PACKET_BYTES));

        hdr_next = hdr_reg;
        tot_next = tot_reg;
        if (pos_reg == '0) begin
            hdr_next = {in_byte_reg[3:0], 2'b00};
        end else if (pos_reg == PW'(2)) begin
            tot_next = {in_byte_reg, tot_reg[7:0]};
        end else if (pos_reg == PW'(3)) begin
            tot_next = {tot_reg[15:8], in_byte_reg};
        end
        hdr16 = {10'd0, hdr_next};

        // ICMP bytes past type/code/checksum that lie inside the total length
        in_icmp = !pos_sat && (hdr_next >= 6'(MIN_IP_HDR_BYTES)) &&
                  (pos16 >= hdr16 + 16'(ICMP_SUM_SKIP)) && (pos16 < tot_next);

        held_next = held_reg;
        sum_next  = sum_reg;
        if (in_icmp) begin
            // header length is a multiple of four, so word parity follows pos[0]
            if (!pos_reg[0]) begin
                held_next = in_byte_reg;
            end else begin
                sum_next = oc_add2(sum_reg, {held_reg, in_byte_reg});
            end
        end

        pos_next = pos_sat ? pos_reg : pos_reg + PW'(1);
        plen16   = 16'(pos_next);

        bad = (plen16 < 16'(MIN_IP_HDR_BYTES)) ||
              (hdr_next < 6'(MIN_IP_HDR_BYTES)) ||
              (hdr16 > plen16) ||
              (tot_next > plen16) ||
              (tot_next < hdr16 + 16'(ICMP_HDR_BYTES));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            hdr_reg  <= '0;
            tot_reg  <= '0;
            sum_reg  <= '0;
            held_reg <= '0;
        end else if (step) begin
            if (in_last_reg) begin
                pos_reg  <= '0;
                hdr_reg  <= '0;
                tot_reg  <= '0;
                sum_reg  <= '0;
                held_reg <= '0;
            end else begin
                pos_reg  <= pos_next;
                hdr_reg  <= hdr_next;
                tot_reg  <= tot_next;
                sum_reg  <= sum_next;
                held_reg <= held_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // finish stage: captures the packet's totals on its final byte
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fin_valid_reg <= 1'b0;
        end else if (step && in_last_reg) begin
            fin_valid_reg <= 1'b1;
        end else if (fin_move) begin
            fin_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && in_last_reg) begin
            fin_drop_reg <= bad;
            fin_hdr_reg  <= hdr_next;
            fin_sum_reg  <= sum_next;
            // odd ICMP length: last byte pads with a low zero byte
            fin_pad_reg  <= tot_next[0] ? held_next : 8'd0;
        end
    end

    // ------------------------------------------------------------------
    // output stage: add type/code word and pad word, complement
    // ------------------------------------------------------------------
    logic [15:0] final_sum;

    assign final_sum = oc_add3(fin_sum_reg, {forced_type_reg, forced_code_reg},
                               {fin_pad_reg, 8'd0});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            pkt_count_reg <= '0;
        end else begin
            if (fin_move) begin
                out_valid_reg <= 1'b1;
                if (!fin_drop_reg) begin
                    pkt_count_reg <= pkt_count_reg + 32'd1;
                end
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fin_move) begin
            out_drop_reg <= fin_drop_reg;
            if (fin_drop_reg) begin
                out_offset_reg <= '0;
                out_type_reg   <= '0;
                out_code_reg   <= '0;
                out_cksum_reg  <= '0;
            end else begin
                out_offset_reg <= fin_hdr_reg;
                out_type_reg   <= forced_type_reg;
                out_code_reg   <= forced_code_reg;
                out_cksum_reg  <= ~final_sum;
            end
        end
    end

    // counter moves in step with the output register, so it always matches the held beat
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_drop_reg;
    assign m_tdata  = {2'b00, pkt_count_reg, out_cksum_reg, out_code_reg, out_type_reg,
                       out_offset_reg};

endmodule
